### src/point_in_sphere_or_cone_test_unit_defines.svh
// ----------------------------------------------------------------------------
// Point in sphere or cone test unit - assertion macros
// Shared concurrent assertion forms for the test unit.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_SPHERE_OR_CONE_TEST_UNIT_DEFINES_SVH
`define POINT_IN_SPHERE_OR_CONE_TEST_UNIT_DEFINES_SVH

// same-cycle implication
`define PSCT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSCT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/psct_pkg.sv
// ----------------------------------------------------------------------------
// Point in sphere or cone test package
// Constants, codes and latency helpers shared by the test unit files.
// ----------------------------------------------------------------------------
package psct_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int RADIUS_WIDTH    = 31;
   localparam int EPS_WIDTH       = 16;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd1;
   localparam int LIMB            = 32;

   typedef enum logic {
      CMD_SPHERE = 1'b0,
      CMD_CONE   = 1'b1
   } cmd_type;

   function automatic int mul_lat(int aw, int bw);
      int na;
      int nb;
      na = (aw + LIMB - 1) / LIMB;
      nb = (bw + LIMB - 1) / LIMB;
      return 1 + $clog2(na * nb);
   endfunction

   function automatic int max2(int a, int b);
      return (a > b) ? a : b;
   endfunction

endpackage

### src/psct_mul.sv
// ----------------------------------------------------------------------------
// Pipelined wide multiplier
// Unsigned product built from 32 x 32 partial products and a registered
// adder tree, with a padding register chain appended when LAT asks for more stages.
// ----------------------------------------------------------------------------
module psct_mul #(
   parameter int AW  = psct_pkg::LIMB,
   parameter int BW  = psct_pkg::LIMB,
   parameter int LAT = psct_pkg::mul_lat(psct_pkg::LIMB, psct_pkg::LIMB)
) (
   input  logic          clock,
   input  logic          en,
   input  logic [AW-1:0] a,
   input  logic [BW-1:0] b,
   output logic [AW+BW-1:0] p
);

   localparam int LB  = psct_pkg::LIMB;
   localparam int NA  = (AW + LB - 1) / LB;
   localparam int NB  = (BW + LB - 1) / LB;
   localparam int NP  = NA * NB;
   localparam int PW  = AW + BW;
   localparam int AXW = NA * LB;
   localparam int BXW = NB * LB;
   localparam int EW  = AXW + BXW;
   localparam int PPW = 2 * LB;
   localparam int LV  = $clog2(NP);
   localparam int PAD = LAT - 1 - LV;

   logic [AXW-1:0] a_ext;
   logic [BXW-1:0] b_ext;
   logic [PW-1:0]  sum_in [0:LV][0:NP-1];
   logic [PW-1:0]  lvl_ff [0:LV][0:NP-1];

   assign a_ext = AXW'(a);
   assign b_ext = BXW'(b);

   always_comb begin
      logic [PPW-1:0] pp;
      int lo;
      int hi;
      for (int k = 0; k <= LV; k++) begin
         for (int n = 0; n < NP; n++) begin
            sum_in[k][n] = '0;
         end
      end
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp = a_ext[i*LB +: LB] * b_ext[j*LB +: LB];
            sum_in[0][i*NB+j] = PW'(EW'(pp) << ((i + j) * LB));
         end
      end
      for (int k = 1; k <= LV; k++) begin
         for (int n = 0; n < NP; n++) begin
            lo = 2 * n;
            hi = 2 * n + 1;
            if (lo < NP) begin
               sum_in[k][n] = lvl_ff[k-1][lo];
            end
            if (hi < NP) begin
               sum_in[k][n] = sum_in[k][n] + lvl_ff[k-1][hi];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= LV; k++) begin
            for (int n = 0; n < NP; n++) begin
               lvl_ff[k][n] <= sum_in[k][n];
            end
         end
      end
   end

   generate
      if (PAD > 0) begin : g_pad
         logic [PW-1:0] pad_ff [0:PAD-1];
         always_ff @(posedge clock) begin
            if (en) begin
               pad_ff[0] <= lvl_ff[LV][0];
               for (int k = 1; k < PAD; k++) begin
                  pad_ff[k] <= pad_ff[k-1];
               end
            end
         end
         assign p = pad_ff[PAD-1];
      end else begin : g_nopad
         assign p = lvl_ff[LV][0];
      end
   endgenerate

endmodule

### src/point_in_sphere_or_cone_test_unit.sv
// ----------------------------------------------------------------------------
// Point in sphere or cone test unit
//
//   channel | direction | handshake        | payload
//   req     | in        | valid / stall    | cmd, point, center a/b, radius a/b
//   rsp     | out       | valid / stall    | inside_res, degenerate
//   csr     | in        | valid / ready    | zero_length_epsilon
//
// One transaction per cycle while req is not stalled; the result passes through the three
// multiplier groups (each a 32 x 32 partial product stage plus its adder tree).
// Reset clears all valid bits and sets the epsilon register to 1.
// A stall on rsp parks one result in a skid register; req stalls while it is full.
// ----------------------------------------------------------------------------
`include "point_in_sphere_or_cone_test_unit_defines.svh"

module point_in_sphere_or_cone_test_unit #(
   parameter int COORD_WIDTH = psct_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_center_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_center_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_b_z,
   input  logic [psct_pkg::RADIUS_WIDTH-1:0] req_radius_a,
   input  logic [psct_pkg::RADIUS_WIDTH-1:0] req_radius_b,

   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_inside_res,
   output logic rsp_degenerate,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [psct_pkg::EPS_WIDTH-1:0] csr_zero_length_epsilon
);

   localparam int CW   = COORD_WIDTH;
   localparam int RW   = psct_pkg::RADIUS_WIDTH;
   localparam int EPW  = psct_pkg::EPS_WIDTH;
   localparam int MW   = CW;
   localparam int SQW  = 2 * MW;
   localparam int SUMW = SQW + 2;
   localparam int DOTW = SUMW + 1;
   localparam int RSQW = 2 * RW;
   localparam int ESQW = 2 * EPW;
   localparam int SPW  = psct_pkg::max2(SUMW, RSQW);
   localparam int PRW  = RW + SUMW;
   localparam int MB   = PRW + 1;
   localparam int TB   = 2 * SUMW;
   localparam int LHW  = TB + SUMW;
   localparam int RHW  = 2 * MB;
   localparam int CMPW = psct_pkg::max2(LHW, RHW);
   localparam int L1   = psct_pkg::max2(psct_pkg::mul_lat(MW, MW),
                                        psct_pkg::mul_lat(RW, RW));
   localparam int L2   = psct_pkg::max2(psct_pkg::mul_lat(RW, SUMW),
                                        psct_pkg::mul_lat(SUMW, SUMW));
   localparam int L3   = psct_pkg::max2(psct_pkg::mul_lat(MB, MB),
                                        psct_pkg::mul_lat(TB, SUMW));

   typedef struct packed {
      psct_pkg::cmd_type cmd;
      logic [RW-1:0]     ra;
      logic [RW-1:0]     rb;
      logic [2:0]        sgn;
   } side1_type;

   typedef struct packed {
      psct_pkg::cmd_type cmd;
      logic              degen;
      logic              off;
      logic              sph;
      logic [SUMW-1:0]   l2;
   } side2_type;

   typedef struct packed {
      psct_pkg::cmd_type cmd;
      logic              degen;
      logic              off;
      logic              sph;
   } side3_type;

   logic adv;
   logic out_free;

   logic [EPW-1:0] eps_ff;

   // stage 1: differences
   logic                     s1_valid_ff;
   psct_pkg::cmd_type        s1_cmd_ff;
   logic [RW-1:0]            s1_ra_ff;
   logic [RW-1:0]            s1_rb_ff;
   logic signed [CW:0]       s1_w_ff [0:2];
   logic signed [CW:0]       s1_v_ff [0:2];
   logic signed [CW-1:0]     pt [0:2];
   logic signed [CW-1:0]     ca [0:2];
   logic signed [CW-1:0]     cb [0:2];

   // stage 2: magnitudes
   logic                     s2_valid_ff;
   psct_pkg::cmd_type        s2_cmd_ff;
   logic [RW-1:0]            s2_ra_ff;
   logic [RW-1:0]            s2_rb_ff;
   logic [MW-1:0]            s2_mw_ff [0:2];
   logic [MW-1:0]            s2_mv_ff [0:2];
   logic [2:0]               s2_sgn_ff;

   // multiplier group 1
   side1_type                side1_in;
   side1_type                g1_side_ff  [0:L1-1];
   logic                     g1_valid_ff [0:L1-1];
   logic [SQW-1:0]           g1_sqw [0:2];
   logic [SQW-1:0]           g1_sqv [0:2];
   logic [SQW-1:0]           g1_wv  [0:2];
   logic [RSQW-1:0]          g1_rasq;

   // stage 3: sums
   logic                     s3_valid_ff;
   psct_pkg::cmd_type        s3_cmd_ff;
   logic [RW-1:0]            s3_ra_ff;
   logic [RW-1:0]            s3_rb_ff;
   logic [SUMW-1:0]          s3_w2_ff;
   logic [SUMW-1:0]          s3_l2_ff;
   logic signed [DOTW-1:0]   s3_dot_ff;
   logic [RSQW-1:0]          s3_rasq_ff;
   logic [ESQW-1:0]          s3_e2_ff;
   logic signed [DOTW-1:0]   dot_in;
   logic [ESQW-1:0]          e2_in;

   // stage 4: range checks
   logic                     s4_valid_ff;
   side2_type                s4_side_ff;
   logic [RW-1:0]            s4_ra_ff;
   logic [RW-1:0]            s4_rb_ff;
   logic [SUMW-1:0]          s4_w2_ff;
   logic [SUMW-1:0]          s4_dl_ff;
   logic [SUMW-1:0]          s4_dotu_ff;
   side2_type                side2_in;

   // multiplier group 2
   side2_type                g2_side_ff  [0:L2-1];
   logic                     g2_valid_ff [0:L2-1];
   logic [PRW-1:0]           g2_pa;
   logic [PRW-1:0]           g2_pb;
   logic [TB-1:0]            g2_wl;
   logic [TB-1:0]            g2_dd;

   // stage 5: scaled radius and distance
   logic                     s5_valid_ff;
   side2_type                s5_side_ff;
   logic [MB-1:0]            s5_m_ff;
   logic [TB-1:0]            s5_t_ff;
   side3_type                side3_in;

   // multiplier group 3
   side3_type                g3_side_ff  [0:L3-1];
   logic                     g3_valid_ff [0:L3-1];
   logic [RHW-1:0]           g3_rhs;
   logic [LHW-1:0]           g3_lhs;

   // stage 6: decision
   logic                     s6_valid_ff;
   logic                     s6_inside_ff;
   logic                     s6_degen_ff;
   logic                     inside_in;
   logic                     degen_in;

   // output and skid
   logic                     rsp_valid_ff;
   logic                     rsp_inside_ff;
   logic                     rsp_degen_ff;
   logic                     skid_valid_ff;
   logic                     skid_inside_ff;
   logic                     skid_degen_ff;

   assign adv       = !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_degenerate = rsp_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= psct_pkg::EPS_RESET;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_zero_length_epsilon;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         for (int k = 0; k < L1; k++) g1_valid_ff[k] <= 1'b0;
         for (int k = 0; k < L2; k++) g2_valid_ff[k] <= 1'b0;
         for (int k = 0; k < L3; k++) g3_valid_ff[k] <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= req_valid;
         s2_valid_ff    <= s1_valid_ff;
         g1_valid_ff[0] <= s2_valid_ff;
         for (int k = 1; k < L1; k++) g1_valid_ff[k] <= g1_valid_ff[k-1];
         s3_valid_ff    <= g1_valid_ff[L1-1];
         s4_valid_ff    <= s3_valid_ff;
         g2_valid_ff[0] <= s4_valid_ff;
         for (int k = 1; k < L2; k++) g2_valid_ff[k] <= g2_valid_ff[k-1];
         s5_valid_ff    <= g2_valid_ff[L2-1];
         g3_valid_ff[0] <= s5_valid_ff;
         for (int k = 1; k < L3; k++) g3_valid_ff[k] <= g3_valid_ff[k-1];
         s6_valid_ff    <= g3_valid_ff[L3-1];
      end
   end

   // stage 1
   always_comb begin
      pt[0] = req_point_x;    pt[1] = req_point_y;    pt[2] = req_point_z;
      ca[0] = req_center_a_x; ca[1] = req_center_a_y; ca[2] = req_center_a_z;
      cb[0] = req_center_b_x; cb[1] = req_center_b_y; cb[2] = req_center_b_z;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff <= psct_pkg::cmd_type'(req_cmd);
         s1_ra_ff  <= req_radius_a;
         s1_rb_ff  <= req_radius_b;
         for (int i = 0; i < 3; i++) begin
            s1_w_ff[i] <= {pt[i][CW-1], pt[i]} - {ca[i][CW-1], ca[i]};
            s1_v_ff[i] <= {cb[i][CW-1], cb[i]} - {ca[i][CW-1], ca[i]};
         end
      end
   end

   // stage 2
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_ra_ff  <= s1_ra_ff;
         s2_rb_ff  <= s1_rb_ff;
         for (int i = 0; i < 3; i++) begin
            s2_mw_ff[i]  <= s1_w_ff[i][CW] ? MW'(-s1_w_ff[i]) : MW'(s1_w_ff[i]);
            s2_mv_ff[i]  <= s1_v_ff[i][CW] ? MW'(-s1_v_ff[i]) : MW'(s1_v_ff[i]);
            s2_sgn_ff[i] <= s1_w_ff[i][CW] ^ s1_v_ff[i][CW];
         end
      end
   end

   // multiplier group 1
   assign side1_in = '{cmd: s2_cmd_ff, ra: s2_ra_ff, rb: s2_rb_ff, sgn: s2_sgn_ff};

   generate
      for (genvar i = 0; i < 3; i++) begin : g_mul1
         psct_mul #(.AW(MW), .BW(MW), .LAT(L1)) u_sqw (
            .clock(clock), .en(adv), .a(s2_mw_ff[i]), .b(s2_mw_ff[i]), .p(g1_sqw[i])
         );
         psct_mul #(.AW(MW), .BW(MW), .LAT(L1)) u_sqv (
            .clock(clock), .en(adv), .a(s2_mv_ff[i]), .b(s2_mv_ff[i]), .p(g1_sqv[i])
         );
         psct_mul #(.AW(MW), .BW(MW), .LAT(L1)) u_wv (
            .clock(clock), .en(adv), .a(s2_mw_ff[i]), .b(s2_mv_ff[i]), .p(g1_wv[i])
         );
      end
   endgenerate

   psct_mul #(.AW(RW), .BW(RW), .LAT(L1)) u_rasq (
      .clock(clock), .en(adv), .a(s2_ra_ff), .b(s2_ra_ff), .p(g1_rasq)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         g1_side_ff[0] <= side1_in;
         for (int k = 1; k < L1; k++) g1_side_ff[k] <= g1_side_ff[k-1];
      end
   end

   // stage 3
   always_comb begin
      logic signed [DOTW-1:0] term;
      dot_in = '0;
      for (int i = 0; i < 3; i++) begin
         term   = DOTW'(g1_wv[i]);
         dot_in = g1_side_ff[L1-1].sgn[i] ? (dot_in - term) : (dot_in + term);
      end
      e2_in = eps_ff * eps_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_cmd_ff  <= g1_side_ff[L1-1].cmd;
         s3_ra_ff   <= g1_side_ff[L1-1].ra;
         s3_rb_ff   <= g1_side_ff[L1-1].rb;
         s3_w2_ff   <= SUMW'(g1_sqw[0]) + SUMW'(g1_sqw[1]) + SUMW'(g1_sqw[2]);
         s3_l2_ff   <= SUMW'(g1_sqv[0]) + SUMW'(g1_sqv[1]) + SUMW'(g1_sqv[2]);
         s3_dot_ff  <= dot_in;
         s3_rasq_ff <= g1_rasq;
         s3_e2_ff   <= e2_in;
      end
   end

   // stage 4
   always_comb begin
      side2_in.cmd   = s3_cmd_ff;
      side2_in.degen = s3_l2_ff <= SUMW'(s3_e2_ff);
      side2_in.off   = s3_dot_ff[DOTW-1] || (s3_dot_ff[SUMW-1:0] > s3_l2_ff);
      side2_in.sph   = SPW'(s3_w2_ff) <= SPW'(s3_rasq_ff);
      side2_in.l2    = s3_l2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_side_ff <= side2_in;
         s4_ra_ff   <= s3_ra_ff;
         s4_rb_ff   <= s3_rb_ff;
         s4_w2_ff   <= s3_w2_ff;
         s4_dl_ff   <= s3_l2_ff - s3_dot_ff[SUMW-1:0];
         s4_dotu_ff <= s3_dot_ff[SUMW-1:0];
      end
   end

   // multiplier group 2
   psct_mul #(.AW(RW), .BW(SUMW), .LAT(L2)) u_pa (
      .clock(clock), .en(adv), .a(s4_ra_ff), .b(s4_dl_ff), .p(g2_pa)
   );
   psct_mul #(.AW(RW), .BW(SUMW), .LAT(L2)) u_pb (
      .clock(clock), .en(adv), .a(s4_rb_ff), .b(s4_dotu_ff), .p(g2_pb)
   );
   psct_mul #(.AW(SUMW), .BW(SUMW), .LAT(L2)) u_wl (
      .clock(clock), .en(adv), .a(s4_w2_ff), .b(s4_side_ff.l2), .p(g2_wl)
   );
   psct_mul #(.AW(SUMW), .BW(SUMW), .LAT(L2)) u_dd (
      .clock(clock), .en(adv), .a(s4_dotu_ff), .b(s4_dotu_ff), .p(g2_dd)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         g2_side_ff[0] <= s4_side_ff;
         for (int k = 1; k < L2; k++) g2_side_ff[k] <= g2_side_ff[k-1];
      end
   end

   // stage 5
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_side_ff <= g2_side_ff[L2-1];
         s5_m_ff    <= MB'(g2_pa) + MB'(g2_pb);
         s5_t_ff    <= g2_wl - g2_dd;
      end
   end

   // multiplier group 3
   psct_mul #(.AW(MB), .BW(MB), .LAT(L3)) u_rhs (
      .clock(clock), .en(adv), .a(s5_m_ff), .b(s5_m_ff), .p(g3_rhs)
   );
   psct_mul #(.AW(TB), .BW(SUMW), .LAT(L3)) u_lhs (
      .clock(clock), .en(adv), .a(s5_t_ff), .b(s5_side_ff.l2), .p(g3_lhs)
   );

   assign side3_in = '{cmd: s5_side_ff.cmd, degen: s5_side_ff.degen,
                       off: s5_side_ff.off, sph: s5_side_ff.sph};

   always_ff @(posedge clock) begin
      if (adv) begin
         g3_side_ff[0] <= side3_in;
         for (int k = 1; k < L3; k++) g3_side_ff[k] <= g3_side_ff[k-1];
      end
   end

   // stage 6
   always_comb begin
      case (g3_side_ff[L3-1].cmd)
         psct_pkg::CMD_SPHERE: begin
            inside_in = g3_side_ff[L3-1].sph;
            degen_in  = 1'b0;
         end
         psct_pkg::CMD_CONE: begin
            degen_in  = g3_side_ff[L3-1].degen;
            inside_in = !g3_side_ff[L3-1].degen && !g3_side_ff[L3-1].off &&
                        (CMPW'(g3_lhs) < CMPW'(g3_rhs));
         end
         default: begin
            inside_in = 1'b0;
            degen_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_inside_ff <= inside_in;
         s6_degen_ff  <= degen_in;
      end
   end

   // output register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_ff <= s6_valid_ff;
      end else if (s6_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_inside_ff <= skid_inside_ff;
            rsp_degen_ff  <= skid_degen_ff;
         end
      end else if (out_free) begin
         rsp_inside_ff <= s6_inside_ff;
         rsp_degen_ff  <= s6_degen_ff;
      end else begin
         skid_inside_ff <= s6_inside_ff;
         skid_degen_ff  <= s6_degen_ff;
      end
   end

   `PSCT_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid full with output empty")
   `PSCT_ASSERT_NXT(a_skid_drain, clock, reset, skid_valid_ff && !rsp_stall, rsp_valid_ff && !skid_valid_ff, "skid did not drain")
   `PSCT_ASSERT_NXT(a_skid_fill, clock, reset, !skid_valid_ff && rsp_valid_ff && rsp_stall && s6_valid_ff, skid_valid_ff, "transaction dropped at output")
   `PSCT_ASSERT_IMP(a_degen_outside, clock, reset, rsp_valid_ff && rsp_degen_ff, !rsp_inside_ff, "degenerate cone reported inside")

endmodule

### dv/tb_point_in_sphere_or_cone_test_unit.sv
// ----------------------------------------------------------------------------
// Point in sphere or cone test unit testbench
// Drives directed and random containment queries through the request channel,
// predicts each answer exactly with wide integer arithmetic, and compares every
// response in order. Epsilon is reprogrammed between phases while the unit is
// idle; requests idle and responses stall at random, with a long response hold-off.
// ----------------------------------------------------------------------------
module tb_point_in_sphere_or_cone_test_unit;

   typedef struct {
      psct_pkg::cmd_type  cmd;
      logic signed [31:0] px, py, pz, ax, ay, az, bx, by, bz;
      logic [30:0]        ra, rb;
   } query_type;

   typedef struct {
      logic hit;
      logic degen;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cmd = 1'b0;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic signed [31:0] req_center_a_x = '0, req_center_a_y = '0, req_center_a_z = '0;
   logic signed [31:0] req_center_b_x = '0, req_center_b_y = '0, req_center_b_z = '0;
   logic [psct_pkg::RADIUS_WIDTH-1:0] req_radius_a = '0, req_radius_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_inside_res, rsp_degenerate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [psct_pkg::EPS_WIDTH-1:0] csr_zero_length_epsilon = '0;

   answer_type answers_due[$];
   logic [psct_pkg::EPS_WIDTH-1:0] epsilon = psct_pkg::EPS_RESET;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic rsp_hold = 1'b0;
   int mismatches = 0;
   int cycles = 0;

   point_in_sphere_or_cone_test_unit uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic answer_type predict_containment(query_type q,
                                                      logic [psct_pkg::EPS_WIDTH-1:0] eps);
      logic signed [79:0] wx, wy, wz, vx, vy, vz;
      logic signed [319:0] dot_s;
      logic [319:0] w2, l2, dot, m, lhs, rhs;
      answer_type r;
      r.hit = 1'b0;
      r.degen = 1'b0;
      wx = q.px - q.ax;
      wy = q.py - q.ay;
      wz = q.pz - q.az;
      vx = q.bx - q.ax;
      vy = q.by - q.ay;
      vz = q.bz - q.az;
      w2 = wx * wx + wy * wy + wz * wz;
      if (q.cmd == psct_pkg::CMD_SPHERE) begin
         r.hit = (w2 <= 320'(q.ra) * 320'(q.ra));
         return r;
      end
      l2 = vx * vx + vy * vy + vz * vz;
      if (l2 <= 320'(eps) * 320'(eps)) begin
         r.degen = 1'b1;
         return r;
      end
      dot_s = wx * vx + wy * vy + wz * vz;
      if (dot_s < 0) return r;
      dot = dot_s;
      if (dot > l2) return r;
      m = 320'(q.ra) * (l2 - dot) + 320'(q.rb) * dot;
      rhs = m * m;
      lhs = (w2 * l2 - dot * dot) * l2;
      r.hit = (lhs < rhs);
      return r;
   endfunction

   // check each response transaction against the oldest prediction
   always @(posedge clock) begin
      answer_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response");
            end else begin
               e = answers_due.pop_front();
               if (rsp_inside_res !== e.hit || rsp_degenerate !== e.degen) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch inside exp %b got %b, degenerate exp %b got %b",
                              e.hit, rsp_inside_res, e.degen, rsp_degenerate);
               end
            end
         end
         rsp_stall <= rsp_hold || ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_query(query_type q);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= q.cmd;
      req_point_x <= q.px;
      req_point_y <= q.py;
      req_point_z <= q.pz;
      req_center_a_x <= q.ax;
      req_center_a_y <= q.ay;
      req_center_a_z <= q.az;
      req_center_b_x <= q.bx;
      req_center_b_y <= q.by;
      req_center_b_z <= q.bz;
      req_radius_a <= q.ra;
      req_radius_b <= q.rb;
      do @(posedge clock); while (req_stall);
      answers_due.insert(answers_due.size(), predict_containment(q, epsilon));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_epsilon(logic [psct_pkg::EPS_WIDTH-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_zero_length_epsilon <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      epsilon = value;
   endtask

   function automatic query_type full_random();
      query_type q;
      q.cmd = psct_pkg::cmd_type'($urandom_range(1));
      q.px = $urandom; q.py = $urandom; q.pz = $urandom;
      q.ax = $urandom; q.ay = $urandom; q.az = $urandom;
      q.bx = $urandom; q.by = $urandom; q.bz = $urandom;
      q.ra = 31'($urandom); q.rb = 31'($urandom);
      return q;
   endfunction

   // shapes near the query point so that inside answers are frequent
   function automatic query_type shaped_random(int span);
      query_type q;
      int f;
      q = full_random();
      q.ax = $signed($urandom_range(1 << 22)) - (1 << 21);
      q.ay = $signed($urandom_range(1 << 22)) - (1 << 21);
      q.az = $signed($urandom_range(1 << 22)) - (1 << 21);
      q.bx = q.ax + $signed($urandom_range(2 * span)) - span;
      q.by = q.ay + $signed($urandom_range(2 * span)) - span;
      q.bz = q.az + $signed($urandom_range(2 * span)) - span;
      f = int'($urandom_range(20)) - 2;
      q.px = q.ax + (q.bx - q.ax) / 16 * f + $signed($urandom_range(span)) - span / 2;
      q.py = q.ay + (q.by - q.ay) / 16 * f + $signed($urandom_range(span)) - span / 2;
      q.pz = q.az + (q.bz - q.az) / 16 * f + $signed($urandom_range(span)) - span / 2;
      q.ra = 31'($urandom_range(span));
      q.rb = 31'($urandom_range(span));
      return q;
   endfunction

   function automatic query_type make_query(psct_pkg::cmd_type c, int px, int ax, int bx,
                                            int ra, int rb);
      query_type q;
      q.cmd = c;
      q.px = px; q.py = 0; q.pz = 0;
      q.ax = ax; q.ay = 0; q.az = 0;
      q.bx = bx; q.by = 0; q.bz = 0;
      q.ra = 31'(ra); q.rb = 31'(rb);
      return q;
   endfunction

   task automatic test_directed();
      query_type q;
      send_query(make_query(psct_pkg::CMD_SPHERE, 0, 0, 0, 0, 0));
      send_query(make_query(psct_pkg::CMD_SPHERE, 65536, 0, 0, 65536, 0));
      send_query(make_query(psct_pkg::CMD_SPHERE, 65537, 0, 0, 65536, 0));
      send_query(make_query(psct_pkg::CMD_SPHERE, 32'h7fffffff, 32'h80000000, 5,
                            31'h7fffffff, 7));
      send_query(make_query(psct_pkg::CMD_CONE, 0, 0, 1, 100, 100));
      send_query(make_query(psct_pkg::CMD_CONE, 0, 0, 2, 100, 100));
      send_query(make_query(psct_pkg::CMD_CONE, -1, 0, 65536, 100, 100));
      send_query(make_query(psct_pkg::CMD_CONE, 65537, 0, 65536, 100, 100));
      send_query(make_query(psct_pkg::CMD_CONE, 0, 0, 65536, 100, 0));
      send_query(make_query(psct_pkg::CMD_CONE, 65536, 0, 65536, 0, 100));
      send_query(make_query(psct_pkg::CMD_CONE, 65536, 0, 65536, 0, 0));
      send_query(make_query(psct_pkg::CMD_CONE, 32768, 0, 65536, 0, 0));
      send_query(make_query(psct_pkg::CMD_CONE, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            31'h7fffffff, 31'h7fffffff));
      q = make_query(psct_pkg::CMD_CONE, 32768, 0, 65536, 1000, 1000);
      q.py = 999;
      send_query(q);
      q.py = 1000;
      send_query(q);
      q = full_random();
      q.px = 32'hffffffff; q.py = 32'hffffffff; q.pz = 32'hffffffff;
      q.ax = 32'hffffffff; q.ay = 32'hffffffff; q.az = 32'hffffffff;
      q.bx = 32'hffffffff; q.by = 32'hffffffff; q.bz = 32'hffffffff;
      q.ra = 31'h7fffffff; q.rb = 31'h7fffffff;
      send_query(q);
      q.cmd = psct_pkg::CMD_SPHERE;
      send_query(q);
   endtask

   task automatic test_random(int count, int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) begin
         if ($urandom_range(4) == 0) send_query(full_random());
         else send_query(shaped_random($urandom_range(1) ? (1 << 20) : (1 << 14)));
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (200) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      repeat (80) send_query(shaped_random(1 << 18));
      drain();
      repeat (20) send_query(shaped_random(1 << 18));
   endtask

   task automatic test_epsilon_sweep();
      write_epsilon(16'd0);
      test_random(60, 10, 10);
      write_epsilon(16'hffff);
      test_random(60, 10, 10);
      write_epsilon(16'($urandom));
      test_random(60, 10, 10);
      write_epsilon(psct_pkg::EPS_RESET);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_epsilon(psct_pkg::EPS_RESET);
      test_directed();
      test_random(250, 27, 61);
      test_random(250, 61, 27);
      test_random(250, 0, 0);
      test_backpressure();
      test_epsilon_sweep();
      drain();
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/psct_pkg.sv
src/psct_mul.sv
src/point_in_sphere_or_cone_test_unit.sv
dv/tb_point_in_sphere_or_cone_test_unit.sv
